@@ src/dgwc_pkg.sv @@
// ----------------------------------------------------------------------------
// Delay gradient window control package
// Widths, reset values, register indexes and helpers shared by the block.
// ----------------------------------------------------------------------------
package dgwc_pkg;

    localparam int TS_W          = 32;
    localparam int DLY_W         = TS_W + 2;
    localparam int SUM_W         = 48;
    localparam int WIN_W         = 32;
    localparam int DGM_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [CFG_DATA_W-1:0] DEF_TIMEOUT  = 16'd600;
    localparam logic [CFG_DATA_W-1:0] DEF_INIT_WIN = 16'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 2'd1;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [WIN_W-1:0] f_load_win(input logic [CFG_DATA_W-1:0] iw,
                                                    input int frac);
        logic [SUM_W-1:0] w;
        w = {{(SUM_W-CFG_DATA_W){1'b0}}, iw} << frac;
        return (|w[SUM_W-1:WIN_W]) ? {WIN_W{1'b1}} : w[WIN_W-1:0];
    endfunction

    function automatic logic [DGM_W-1:0] f_win_int(input logic [WIN_W-1:0] win,
                                                   input int frac);
        logic [WIN_W-1:0] s;
        s = win >> frac;
        return (|s[WIN_W-1:DGM_W]) ? {DGM_W{1'b1}} : s[DGM_W-1:0];
    endfunction

    function automatic logic [DGM_W-1:0] f_floor1(input logic [DGM_W-1:0] a);
        return (a == '0) ? DGM_W'(1) : a;
    endfunction

endpackage

@@ src/dgwc_div.sv @@
// ----------------------------------------------------------------------------
// Growth quotient divider
// Restoring divider, one quotient bit per cycle: num * 2^(2*FRAC_BITS) / den,
// saturated to the window width.
// ----------------------------------------------------------------------------
module dgwc_div #(
    parameter int FRAC_BITS = dgwc_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dgwc_pkg::SUM_W-1:0]    i_num,
    input  logic [dgwc_pkg::SUM_W-1:0]    i_den,
    output dgwc_pkg::t_div_sts            o_sts,
    output logic [dgwc_pkg::WIN_W-1:0]    o_quot
);

    localparam int SUM_W = dgwc_pkg::SUM_W;
    localparam int WIN_W = dgwc_pkg::WIN_W;
    localparam int ITERS = SUM_W + 2 * FRAC_BITS;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] r_num;
    logic [SUM_W-1:0] r_den;
    logic [SUM_W-1:0] r_rem;
    logic [WIN_W-1:0] r_q;
    logic             r_ovf;
    logic             r_zden;
    logic             r_nz;

    logic [SUM_W:0]   rem_sh;
    logic [SUM_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {r_rem, r_num[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_zden <= (i_den == '0);
            r_nz   <= (i_num != '0);
        end else if (r_busy) begin
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_rem <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            r_q   <= {r_q[WIN_W-2:0], ge};
            r_ovf <= r_ovf | r_q[WIN_W-1];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = (r_zden && !r_nz) ? '0 : (r_ovf ? {WIN_W{1'b1}} : r_q);

endmodule

@@ src/delay_gradient_window_control.sv @@
// ----------------------------------------------------------------------------
// Delay gradient window control
// Congestion window driven by send and ack events, halved on timeouts and
// congested epochs, grown by 1 + |down| / (timeout * window) otherwise.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A send or the first ack goes
// straight to the output state. A later ack runs the bit-serial delay
// subtractor and then the bit-serial accumulator. An ack that ends an epoch
// adds a serial compare of the two totals, then either a halving or, for
// growth, a multiply, the one bit per cycle divider and the window update.
// A finished result waits in the output register while the next transaction
// is taken.
module delay_gradient_window_control #(
    parameter int FRAC_BITS = dgwc_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic                               i_timeout_flag,
    input  logic [dgwc_pkg::TS_W-1:0]          i_send_time,
    input  logic [dgwc_pkg::TS_W-1:0]          i_ack_time,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [dgwc_pkg::DGM_W-1:0]         o_window_datagrams,
    output logic                               o_congested,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dgwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dgwc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TS_W  = dgwc_pkg::TS_W;
    localparam int DLY_W = dgwc_pkg::DLY_W;
    localparam int SUM_W = dgwc_pkg::SUM_W;
    localparam int WIN_W = dgwc_pkg::WIN_W;
    localparam int DGM_W = dgwc_pkg::DGM_W;
    localparam int CNT_W = $clog2(SUM_W);

    localparam logic [CNT_W-1:0] DLY_LAST = CNT_W'(DLY_W - 1);
    localparam logic [CNT_W-1:0] SUM_LAST = CNT_W'(SUM_W - 1);
    localparam logic [WIN_W+1:0] ONE_Q    = (WIN_W + 2)'(1) << FRAC_BITS;

    localparam logic [WIN_W-1:0] RST_WIN  = dgwc_pkg::f_load_win(dgwc_pkg::DEF_INIT_WIN,
                                                                FRAC_BITS);
    localparam logic [DGM_W-1:0] RST_ACKS = dgwc_pkg::f_floor1(
                                                dgwc_pkg::f_win_int(RST_WIN, FRAC_BITS));

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DELTA = 4'd1;
    localparam logic [3:0] ST_ACC   = 4'd2;
    localparam logic [3:0] ST_CMP   = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_DIVGO = 4'd5;
    localparam logic [3:0] ST_DIVW  = 4'd6;
    localparam logic [3:0] ST_RLD   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_have_prev;
    logic             r_out_valid;
    logic [DGM_W-1:0] r_out_win;
    logic             r_out_cong;
    logic [15:0]      r_tmo;
    logic [WIN_W-1:0] r_win;
    logic [DGM_W-1:0] r_acks;
    logic [SUM_W-1:0] r_up;
    logic [SUM_W-1:0] r_down;
    logic             r_epoch;
    logic             r_cong;

    logic [TS_W-1:0]  r_at;
    logic [TS_W-1:0]  r_st;
    logic [TS_W-1:0]  r_pa;
    logic [TS_W-1:0]  r_ps;
    logic             r_c_da;
    logic             r_c_ds;
    logic             r_c_d;
    logic             r_da_msb;
    logic             r_ds_msb;
    logic [DLY_W-1:0] r_dly;
    logic             r_c_acc;
    logic             r_gt;
    logic [SUM_W-1:0] r_den;

    logic             in_acc;
    logic             cfg_wr;
    logic             out_load;
    logic [DGM_W-1:0] acks_dec;
    logic [WIN_W-1:0] cfg_win;

    logic             ts_phase;
    logic             da_b;
    logic             ds_b;
    logic             d_b;
    logic             c_da_n;
    logic             c_ds_n;
    logic             c_d_n;

    logic             acc_pos;
    logic             acc_a;
    logic             acc_t;
    logic             acc_s;
    logic             acc_cn;
    logic             acc_last;
    logic [SUM_W-1:0] acc_new;

    logic             cmp_gt_n;
    logic             cmp_last;

    logic [SUM_W-1:0] den_c;
    logic [WIN_W+1:0] win_sum;
    logic [WIN_W-1:0] win_grow;

    dgwc_pkg::t_div_sts   div_sts;
    logic [WIN_W-1:0]     div_quot;

    dgwc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIVGO),
        .i_num   (r_down),
        .i_den   (r_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_in_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign acks_dec    = (r_acks == '0) ? '0 : r_acks - DGM_W'(1);
    assign cfg_win     = dgwc_pkg::f_load_win(i_cfg_data, FRAC_BITS);

    // Serial subtractors: ack gap, send gap, then their difference
    assign ts_phase = r_cnt < CNT_W'(TS_W);
    assign da_b     = ts_phase ? (r_at[0] ^ ~r_pa[0] ^ r_c_da) : r_da_msb;
    assign ds_b     = ts_phase ? (r_st[0] ^ ~r_ps[0] ^ r_c_ds) : r_ds_msb;
    assign c_da_n   = (r_at[0] & ~r_pa[0]) | (r_at[0] & r_c_da) | (~r_pa[0] & r_c_da);
    assign c_ds_n   = (r_st[0] & ~r_ps[0]) | (r_st[0] & r_c_ds) | (~r_ps[0] & r_c_ds);
    assign d_b      = da_b ^ ~ds_b ^ r_c_d;
    assign c_d_n    = (da_b & ~ds_b) | (da_b & r_c_d) | (~ds_b & r_c_d);

    // Serial accumulate of the delay magnitude into the selected total
    assign acc_pos  = !r_dly[DLY_W-1];
    assign acc_a    = r_dly[0] ^ r_dly[DLY_W-1];
    assign acc_t    = acc_pos ? r_up[0] : r_down[0];
    assign acc_s    = acc_t ^ acc_a ^ r_c_acc;
    assign acc_cn   = (acc_t & acc_a) | (acc_t & r_c_acc) | (acc_a & r_c_acc);
    assign acc_last = (r_cnt == SUM_LAST);
    assign acc_new  = (acc_last && acc_cn) ? {SUM_W{1'b1}}
                    : {acc_s, (acc_pos ? r_up[SUM_W-1:1] : r_down[SUM_W-1:1])};

    assign cmp_gt_n = (r_up[0] & ~r_down[0]) | (~(r_up[0] ^ r_down[0]) & r_gt);
    assign cmp_last = (r_cnt == SUM_LAST);

    assign den_c    = SUM_W'(r_tmo) * SUM_W'(r_win);
    assign win_sum  = {2'b00, r_win} + ONE_Q + {2'b00, div_quot};
    assign win_grow = (|win_sum[WIN_W+1:WIN_W]) ? {WIN_W{1'b1}} : win_sum[WIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_tmo       <= dgwc_pkg::DEF_TIMEOUT;
            r_win       <= RST_WIN;
            r_acks      <= RST_ACKS;
            r_up        <= '0;
            r_down      <= '0;
            r_epoch     <= 1'b0;
            r_cong      <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cong  <= 1'b0;
                        r_epoch <= 1'b0;
                        if (i_opcode == dgwc_pkg::OP_SEND) begin
                            if (i_timeout_flag) begin
                                r_win <= r_win >> 1;
                            end
                            r_state <= ST_OUT;
                        end else if (!r_have_prev) begin
                            r_have_prev <= 1'b1;
                            r_state     <= ST_OUT;
                        end else begin
                            r_acks  <= acks_dec;
                            r_epoch <= (acks_dec == '0);
                            r_cnt   <= '0;
                            r_state <= ST_DELTA;
                        end
                    end
                end
                ST_DELTA: begin
                    if (r_cnt == DLY_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_ACC;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_ACC: begin
                    if (acc_pos) begin
                        r_up <= acc_new;
                    end else begin
                        r_down <= acc_new;
                    end
                    if (acc_last) begin
                        r_cnt   <= '0;
                        r_state <= r_epoch ? ST_CMP : ST_OUT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_CMP: begin
                    if (cmp_last && cmp_gt_n) begin
                        r_win   <= r_win >> 1;
                        r_cong  <= 1'b1;
                        r_up    <= '0;
                        r_down  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_RLD;
                    end else begin
                        r_up   <= {r_up[0], r_up[SUM_W-1:1]};
                        r_down <= {r_down[0], r_down[SUM_W-1:1]};
                        if (cmp_last) begin
                            r_cnt   <= '0;
                            r_state <= ST_MUL;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIVGO;
                end
                ST_DIVGO: begin
                    r_up    <= '0;
                    r_down  <= '0;
                    r_state <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (div_sts.done) begin
                        r_win   <= win_grow;
                        r_state <= ST_RLD;
                    end
                end
                ST_RLD: begin
                    r_acks  <= dgwc_pkg::f_floor1(dgwc_pkg::f_win_int(r_win, FRAC_BITS));
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (cfg_wr) begin
                if (i_cfg_index == dgwc_pkg::CFG_TIMEOUT) begin
                    r_tmo <= i_cfg_data;
                end else if (i_cfg_index == dgwc_pkg::CFG_INIT_WIN) begin
                    r_win  <= cfg_win;
                    r_acks <= dgwc_pkg::f_floor1(dgwc_pkg::f_win_int(cfg_win, FRAC_BITS));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == dgwc_pkg::OP_ACK) begin
            if (!r_have_prev) begin
                r_pa <= i_ack_time;
                r_ps <= i_send_time;
            end else begin
                r_at   <= i_ack_time;
                r_st   <= i_send_time;
                r_c_da <= 1'b1;
                r_c_ds <= 1'b1;
                r_c_d  <= 1'b1;
            end
        end

        if (r_state == ST_DELTA) begin
            if (ts_phase) begin
                r_at     <= r_at >> 1;
                r_st     <= r_st >> 1;
                r_pa     <= {r_at[0], r_pa[TS_W-1:1]};
                r_ps     <= {r_st[0], r_ps[TS_W-1:1]};
                r_c_da   <= c_da_n;
                r_c_ds   <= c_ds_n;
                r_da_msb <= da_b;
                r_ds_msb <= ds_b;
            end
            r_c_d <= c_d_n;
            r_dly <= {d_b, r_dly[DLY_W-1:1]};
            if (r_cnt == DLY_LAST) begin
                r_c_acc <= d_b;
            end
        end

        if (r_state == ST_ACC) begin
            r_dly   <= {r_dly[DLY_W-1], r_dly[DLY_W-1:1]};
            r_c_acc <= acc_cn;
            r_gt    <= 1'b0;
        end

        if (r_state == ST_CMP) begin
            r_gt <= cmp_gt_n;
        end

        if (r_state == ST_MUL) begin
            r_den <= den_c;
        end

        if (out_load) begin
            r_out_win  <= dgwc_pkg::f_win_int(r_win, FRAC_BITS);
            r_out_cong <= r_cong;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_window_datagrams = r_out_win;
    assign o_congested        = r_out_cong;

    a_acks_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_acks != '0)
        else $error("ack counter zero while idle");

    a_div_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIVW |-> div_sts.busy || div_sts.done)
        else $error("waiting on an idle divider");

    a_epoch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && r_epoch |-> r_up == '0 && r_down == '0)
        else $error("totals not cleared at epoch end");

    a_cong_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && r_cong |-> r_epoch)
        else $error("congested outside an epoch end");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Delay gradient window control testbench
// Sends send and ack transactions into the block and predicts every window
// update with a behavioural model of the window controller. Each output
// transaction is checked in order against that prediction, or against the
// result that a directed row gives. A directed table runs first, then three
// random phases with varied register settings and idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC          = dgwc_pkg::DEF_FRAC_BITS;
    localparam int TS_W          = dgwc_pkg::TS_W;
    localparam int WIN_W         = dgwc_pkg::WIN_W;
    localparam int DGM_W         = dgwc_pkg::DGM_W;
    localparam int CFG_IDX_W     = dgwc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = dgwc_pkg::CFG_DATA_W;
    localparam int HOLD_CYCLES   = 600;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 400;
    localparam int BATCH_ITEMS   = 45;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] WIN_MAX = 64'hFFFF_FFFF;

    typedef enum logic {ROW_EVENT, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [DGM_W-1:0] win;
        logic             cong;
    } t_window_result;

    typedef struct packed {
        t_row_kind              kind;
        logic                   op;
        logic                   tflag;
        logic [TS_W-1:0]        st;
        logic [TS_W-1:0]        at;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   known;
        t_window_result         res;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_opcode;
    logic                   i_timeout_flag;
    logic [TS_W-1:0]        i_send_time;
    logic [TS_W-1:0]        i_ack_time;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [DGM_W-1:0]       o_window_datagrams;
    logic                   o_congested;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // window controller model state
    logic [CFG_DATA_W-1:0]  timeout_reg;
    logic [WIN_W-1:0]       cwnd_q;
    logic [DGM_W-1:0]       epoch_acks;
    logic [63:0]            rise_sum;
    logic [63:0]            fall_sum;
    logic [TS_W-1:0]        last_send_ts;
    logic [TS_W-1:0]        last_ack_ts;
    logic                   seen_ack;

    t_window_result pending_results[$];
    int             fail_count   = 0;
    int             quiet_cycles = 0;
    int             tx_idle_pct  = 0;
    int             rx_idle_pct  = 0;
    int             hold_req     = 0;
    logic [TS_W-1:0] snd_clock;
    int             rtt_ms;

    delay_gradient_window_control #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_timeout_flag     (i_timeout_flag),
        .i_send_time        (i_send_time),
        .i_ack_time         (i_ack_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_datagrams (o_window_datagrams),
        .o_congested        (o_congested),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [DGM_W-1:0] whole_datagrams(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] s;
        s = w >> FRAC;
        return (s > 32'd65535) ? 16'hFFFF : s[DGM_W-1:0];
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    // floor(num * 2^(2*FRAC) / den), clipped to the window width
    function automatic logic [WIN_W-1:0] growth_term(input logic [63:0] num,
                                                     input logic [63:0] den);
        logic [127:0] q;
        if (den == 0) begin
            return (num == 0) ? '0 : WIN_MAX[WIN_W-1:0];
        end
        q = ({64'd0, num} << (2 * FRAC)) / {64'd0, den};
        return (q > {64'd0, WIN_MAX}) ? WIN_MAX[WIN_W-1:0] : q[WIN_W-1:0];
    endfunction

    function automatic t_stim_row ev_row(input logic op, input logic tflag,
                                         input logic [TS_W-1:0] st, input logic [TS_W-1:0] at,
                                         input logic known, input logic [DGM_W-1:0] win,
                                         input logic cong);
        t_stim_row r;
        r = '0;
        r.kind     = ROW_EVENT;
        r.op       = op;
        r.tflag    = tflag;
        r.st       = st;
        r.at       = at;
        r.known    = known;
        r.res.win  = win;
        r.res.cong = cong;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    task automatic reload_epoch();
        epoch_acks = whole_datagrams(cwnd_q);
        if (epoch_acks == '0) begin
            epoch_acks = DGM_W'(1);
        end
    endtask

    task automatic model_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        logic [63:0] w;
        case (idx)
            dgwc_pkg::CFG_TIMEOUT: begin
                timeout_reg = data;
            end
            dgwc_pkg::CFG_INIT_WIN: begin
                w = 64'(data) << FRAC;
                cwnd_q = (w > WIN_MAX) ? WIN_MAX[WIN_W-1:0] : w[WIN_W-1:0];
                reload_epoch();
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_window(input logic op, input logic tflag,
                                  input logic [TS_W-1:0] st, input logic [TS_W-1:0] at,
                                  output t_window_result res);
        logic [TS_W-1:0]    send_gap;
        logic [TS_W-1:0]    ack_gap;
        logic signed [63:0] dly;
        logic [63:0]        grown;
        res.cong = 1'b0;
        if (op == dgwc_pkg::OP_SEND) begin
            if (tflag) begin
                cwnd_q = cwnd_q >> 1;
            end
        end else if (!seen_ack) begin
            last_send_ts = st;
            last_ack_ts  = at;
            seen_ack     = 1'b1;
        end else begin
            send_gap = st - last_send_ts;
            ack_gap  = at - last_ack_ts;
            dly = $signed({{32{ack_gap[31]}}, ack_gap})
                - $signed({{32{send_gap[31]}}, send_gap});
            if (dly > 0) begin
                rise_sum = sat_sum(rise_sum, dly);
            end else begin
                fall_sum = sat_sum(fall_sum, -dly);
            end
            if (epoch_acks == '0) begin
                epoch_acks = DGM_W'(1);
            end
            epoch_acks = epoch_acks - DGM_W'(1);
            if (epoch_acks == '0) begin
                if (rise_sum > fall_sum) begin
                    cwnd_q   = cwnd_q >> 1;
                    res.cong = 1'b1;
                end else begin
                    grown = 64'(cwnd_q) + (64'd1 << FRAC)
                          + 64'(growth_term(fall_sum, 64'(timeout_reg) * 64'(cwnd_q)));
                    cwnd_q = (grown > WIN_MAX) ? WIN_MAX[WIN_W-1:0] : grown[WIN_W-1:0];
                end
                reload_epoch();
                rise_sum = '0;
                fall_sum = '0;
            end
            last_send_ts = st;
            last_ack_ts  = at;
        end
        res.win = whole_datagrams(cwnd_q);
    endtask

    task automatic offer_event(input logic op, input logic tflag,
                               input logic [TS_W-1:0] st, input logic [TS_W-1:0] at,
                               input logic known, input t_window_result typed);
        t_window_result res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_timeout_flag <= tflag;
        i_send_time    <= st;
        i_ack_time     <= at;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_window(op, tflag, st, at, res);
        pending_results.push_back(known ? typed : res);
    endtask

    task automatic offer_random_event();
        int              roll;
        int              jitter;
        logic            tflag;
        roll   = $urandom_range(0, 99);
        jitter = $urandom_range(0, 24);
        tflag  = 1'($urandom_range(0, 1));
        snd_clock = snd_clock + TS_W'($urandom_range(1, 40));
        rtt_ms = rtt_ms + jitter - 12;
        if (rtt_ms < 5) begin
            rtt_ms = 5;
        end else if (rtt_ms > 600) begin
            rtt_ms = 600;
        end
        if (roll < 10) begin
            offer_event(dgwc_pkg::OP_SEND, $urandom_range(0, 2) == 0, $urandom, $urandom,
                        1'b0, '0);
        end else if (roll < 96) begin
            offer_event(dgwc_pkg::OP_ACK, tflag, snd_clock, snd_clock + TS_W'(rtt_ms),
                        1'b0, '0);
        end else begin
            offer_event(dgwc_pkg::OP_ACK, tflag, $urandom, $urandom, 1'b0, '0);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        model_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic await_window_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : rx_side
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_window_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected transaction win=%0d congested=%0b",
                         $time, o_window_datagrams, o_congested);
            end else begin
                want = pending_results.pop_front();
                if (o_window_datagrams !== want.win) begin
                    fail_count++;
                    $display("%0t: window_datagrams expected %0d actual %0d",
                             $time, want.win, o_window_datagrams);
                end
                if (o_congested !== want.cong) begin
                    fail_count++;
                    $display("%0t: congested expected %0b actual %0b",
                             $time, want.cong, o_congested);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("[delay_gradient_window_control] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row dir_tbl[$];
        t_stim_row row;
        int        phase;
        int        pick;
        logic [CFG_DATA_W-1:0] tmo;
        logic [CFG_DATA_W-1:0] iw;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = dgwc_pkg::OP_SEND;
        i_timeout_flag = 1'b0;
        i_send_time    = '0;
        i_ack_time     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = dgwc_pkg::CFG_TIMEOUT;
        i_cfg_data     = '0;
        snd_clock      = $urandom;
        rtt_ms         = $urandom_range(20, 200);

        model_config(dgwc_pkg::CFG_TIMEOUT, dgwc_pkg::DEF_TIMEOUT);
        model_config(dgwc_pkg::CFG_INIT_WIN, dgwc_pkg::DEF_INIT_WIN);
        rise_sum     = '0;
        fall_sum     = '0;
        last_send_ts = '0;
        last_ack_ts  = '0;
        seen_ack     = 1'b0;

        dir_tbl.push_back(ev_row(dgwc_pkg::OP_SEND, 1'b0, 32'h0, 32'h0,
                                 1'b1, 16'd128, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_SEND, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 1'b1, 16'd64, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b1, 32'd5, 32'd9,
                                 1'b1, 16'd64, 1'b0));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_INIT_WIN, 16'd2));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'd15, 32'd39, 1'b0, '0, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'd25, 32'd44,
                                 1'b1, 16'd1, 1'b1));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'd35, 32'd54, 1'b0, '0, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'hFFFF_FFF0, 32'h10,
                                 1'b0, '0, 1'b0));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_TIMEOUT, 16'd1));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_INIT_WIN, 16'd1));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'h7FFF_FFF0, 32'h8000_000F,
                                 1'b1, 16'd0, 1'b1));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'hFFFF_FFEF, 32'h0000_000F,
                                 1'b1, 16'hFFFF, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_SEND, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0,
                                 1'b1, 16'd32767, 1'b0));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_TIMEOUT, 16'd0));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_INIT_WIN, 16'd0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_SEND, 1'b1, 32'h0, 32'h0,
                                 1'b1, 16'd0, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'h53, 32'h73,
                                 1'b1, 16'd1, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'h5D, 32'h78,
                                 1'b1, 16'hFFFF, 1'b0));
        dir_tbl.push_back(cfg_row(CFG_SPARE, 16'hFFFF));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_TIMEOUT, 16'hFFFF));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_INIT_WIN, 16'hFFFF));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'h67, 32'h78,
                                 1'b1, 16'hFFFF, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_SEND, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                 1'b1, 16'd32767, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_SEND, 1'b0, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                                 1'b1, 16'd32767, 1'b0));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_INIT_WIN, 16'd3));
        dir_tbl.push_back(cfg_row(dgwc_pkg::CFG_TIMEOUT, 16'd7));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'h7B, 32'h82, 1'b0, '0, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b1, 32'h8F, 32'hAA, 1'b0, '0, 1'b0));
        dir_tbl.push_back(ev_row(dgwc_pkg::OP_ACK, 1'b0, 32'hAD, 32'hAF, 1'b0, '0, 1'b0));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 11;
        rx_idle_pct = 58;
        foreach (dir_tbl[r]) begin
            row = dir_tbl[r];
            if (row.kind == ROW_CFG) begin
                await_window_results();
                write_reg(row.idx, row.data);
            end else begin
                offer_event(row.op, row.tflag, row.st, row.at, row.known, row.res);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 58 : 0;
            rx_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 11 : 0;
            for (int batch = 0; batch < 3; batch++) begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: tmo = 16'd1;
                    1: tmo = CFG_DATA_W'($urandom_range(1, 50));
                    2: tmo = CFG_DATA_W'($urandom_range(1, 65535));
                    default: tmo = 16'hFFFF;
                endcase
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    iw = CFG_DATA_W'($urandom_range(1, 6));
                end else if (pick < 9) begin
                    iw = CFG_DATA_W'($urandom_range(7, 20));
                end else begin
                    iw = 16'd1;
                end
                await_window_results();
                write_reg(dgwc_pkg::CFG_TIMEOUT, tmo);
                write_reg(dgwc_pkg::CFG_INIT_WIN, iw);
                // hold the output side off so the block backs up
                if (phase == 0 && batch == 0) begin
                    @(posedge i_clk);
                    hold_req = HOLD_CYCLES;
                end
                repeat (BATCH_ITEMS) offer_random_event();
            end
        end

        await_window_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[delay_gradient_window_control] OK");
        end else begin
            $display("[delay_gradient_window_control] ERROR");
        end
        $finish;
    end

endmodule
